>>> sv/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared codes and word layout for the strongly connected components block.
// No dependencies; imported by the top level.
package scc_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] KIND_NEW    = 2'd0;
	localparam logic [1:0] KIND_ADD    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_FIND   = 2'd3;

	// Result status codes carried on the output tuser.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_GRAPH  = 2'd1;
	localparam logic [1:0] ST_BAD_RANGE = 2'd2;

	// Packed word widths.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

endpackage

`default_nettype wire

>>> sv/scc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for every memory of the block.
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/strongly_connected_components.sv
`timescale 1ns / 1ps
`default_nettype none
// Strongly connected components of a small directed graph (Kosaraju search).
// The slave channel takes one request word: tuser holds the kind, tdata holds
// from_vertex, to_vertex and vertex_count. The master channel returns result
// words: tuser holds the status, tlast marks the final word of a request.
// A new graph sweeps all MAX_VERTICES adjacency rows, one per cycle. An edge
// edit is a read-modify-write of one row. A search probes one candidate
// neighbour at a time, in a scan state and a check state, through the single
// adjacency RAM read port, in both the forward and the transposed pass, and
// then returns N result words for N vertices.
// The block takes one request at a time; tready is low from acceptance until
// the last result word has left the output register.
// A stalled receiver simply holds the output register and the sequencer.
// Reset clears the graph-present flag, the control state and the output
// valid; adjacency contents are undefined until a new graph is started.
module strongly_connected_components
	import scc_pkg::*;
#(
	parameter int MAX_VERTICES = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// from_vertex[5:0], to_vertex[11:6], vertex_count[17:12], zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// vertex[5:0], component[11:6], component_total[17:12],
	// last_in_component[18], zero fill
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int PW = $clog2(MAX_VERTICES + 1);
	localparam logic [6:0] MAX_C = 7'(MAX_VERTICES);

	// Sequencer states.
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CLR      = 4'd1;
	localparam logic [3:0] S_EDGE_RD  = 4'd2;
	localparam logic [3:0] S_EDGE_WR  = 4'd3;
	localparam logic [3:0] S_P1_START = 4'd4;
	localparam logic [3:0] S_SCAN     = 4'd5;
	localparam logic [3:0] S_CHECK    = 4'd6;
	localparam logic [3:0] S_FINISH   = 4'd7;
	localparam logic [3:0] S_POP      = 4'd8;
	localparam logic [3:0] S_P2_INIT  = 4'd9;
	localparam logic [3:0] S_P2_NEXT  = 4'd10;
	localparam logic [3:0] S_P2_GET   = 4'd11;
	localparam logic [3:0] S_EM_RD    = 4'd12;
	localparam logic [3:0] S_EM_LD    = 4'd13;
	localparam logic [3:0] S_EM_WAIT  = 4'd14;

	logic [3:0]              st_q;
	logic [PW-1:0]           n_q;
	logic                    present_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [PW-1:0]           s_q;
	logic [IW-1:0]           cur_v_q;
	logic [PW-1:0]           cur_p_q;
	logic [PW-1:0]           sp_q;
	logic [PW-1:0]           fd_q;
	logic [PW-1:0]           comps_q;
	logic [PW-1:0]           k_q;
	logic [PW-1:0]           e_q;
	logic [IW-1:0]           last_v_q;
	logic                    pass2_q;
	logic [IW-1:0]           clr_q;
	logic [1:0]              kind_q;
	logic [5:0]              f_q;
	logic [5:0]              t_q;

	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic [5:0]              out_vertex_q;
	logic [5:0]              out_comp_q;
	logic [5:0]              out_total_q;
	logic                    out_lic_q;
	logic                    out_last_q;

	// Input word fields.
	logic [1:0] in_kind;
	logic [5:0] in_from;
	logic [5:0] in_to;
	logic [5:0] in_count;
	assign in_kind  = s_tuser;
	assign in_from  = s_tdata[5:0];
	assign in_to    = s_tdata[11:6];
	assign in_count = s_tdata[17:12];

	// Memory ports.
	logic                    adj_we;
	logic [IW-1:0]           adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic [IW-1:0]           adj_raddr;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic                    stk_we;
	logic [IW+PW-1:0]        stk_wdata;
	logic [IW+PW-1:0]        stk_rdata;
	logic                    fin_we;
	logic [IW-1:0]           fin_rdata;
	logic                    res_we;
	logic [IW-1:0]           res_waddr;
	logic [IW+PW:0]          res_wdata;
	logic [IW+PW:0]          res_rdata;

	logic [5:0]    f_m1;
	logic [5:0]    t_m1;
	logic [IW-1:0] p_idx;
	logic [PW-1:0] sp_m1;
	logic [PW-1:0] fd_m1;
	logic [PW-1:0] k_m1;
	logic          probe_hit;
	logic          accept;

	assign f_m1  = f_q - 6'd1;
	assign t_m1  = t_q - 6'd1;
	assign p_idx = cur_p_q[IW-1:0];
	assign sp_m1 = sp_q - PW'(1);
	assign fd_m1 = fd_q - PW'(1);
	assign k_m1  = k_q - PW'(1);
	assign probe_hit = (pass2_q ? adj_rdata[cur_v_q] : adj_rdata[p_idx]) && !visited_q[p_idx];

	assign s_tready = (st_q == S_IDLE) && !out_valid_q;
	assign accept   = s_tvalid && s_tready;

	// Memory addressing and write data for the current sequencer step.
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = clr_q;
		adj_wdata = '0;
		stk_we    = 1'b0;
		stk_wdata = {cur_v_q, cur_p_q + PW'(1)};
		fin_we    = 1'b0;
		res_we    = 1'b0;
		res_waddr = k_q[IW-1:0];
		res_wdata = {p_idx, comps_q, 1'b0};
		adj_raddr = pass2_q ? p_idx : cur_v_q;
		if (st_q == S_EDGE_RD || st_q == S_EDGE_WR) begin
			adj_raddr = f_m1[IW-1:0];
		end
		unique case (st_q)
			S_CLR: begin
				adj_we = 1'b1;
			end
			S_EDGE_WR: begin
				adj_we    = 1'b1;
				adj_waddr = f_m1[IW-1:0];
				if (kind_q == KIND_ADD) begin
					adj_wdata = adj_rdata | (MAX_VERTICES'(1) << t_m1[IW-1:0]);
				end else begin
					adj_wdata = adj_rdata & ~(MAX_VERTICES'(1) << t_m1[IW-1:0]);
				end
			end
			S_CHECK: begin
				if (cur_p_q != n_q && probe_hit) begin
					stk_we = 1'b1;
					res_we = pass2_q;
				end
			end
			S_FINISH: begin
				fin_we = !pass2_q;
				if (pass2_q && sp_q == '0) begin
					res_we    = 1'b1;
					res_waddr = k_m1[IW-1:0];
					res_wdata = {last_v_q, comps_q, 1'b1};
				end
			end
			S_P2_GET: begin
				if (!visited_q[fin_rdata]) begin
					res_we    = 1'b1;
					res_wdata = {fin_rdata, comps_q + PW'(1), 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer for graph clears, edge edits, the two depth-first passes and result output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			n_q         <= '0;
			present_q   <= 1'b0;
			visited_q   <= '0;
			s_q         <= '0;
			cur_v_q     <= '0;
			cur_p_q     <= '0;
			sp_q        <= '0;
			fd_q        <= '0;
			comps_q     <= '0;
			k_q         <= '0;
			e_q         <= '0;
			pass2_q     <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						kind_q       <= in_kind;
						f_q          <= in_from;
						t_q          <= in_to;
						out_status_q <= ST_OK;
						out_vertex_q <= '0;
						out_comp_q   <= '0;
						out_total_q  <= '0;
						out_lic_q    <= 1'b0;
						out_last_q   <= 1'b1;
						if (in_kind == KIND_NEW) begin
							if (in_count == 6'd0 || 7'(in_count) > MAX_C) begin
								out_status_q <= ST_BAD_RANGE;
								out_valid_q  <= 1'b1;
							end else begin
								n_q       <= PW'(in_count);
								present_q <= 1'b1;
								clr_q     <= '0;
								st_q      <= S_CLR;
							end
						end else if (!present_q) begin
							out_status_q <= ST_NO_GRAPH;
							out_valid_q  <= 1'b1;
						end else if (in_kind == KIND_FIND) begin
							visited_q <= '0;
							fd_q      <= '0;
							s_q       <= '0;
							pass2_q   <= 1'b0;
							st_q      <= S_P1_START;
						end else if (in_from == 6'd0 || 7'(in_from) > 7'(n_q) ||
						             in_to == 6'd0 || 7'(in_to) > 7'(n_q)) begin
							out_status_q <= ST_BAD_RANGE;
							out_valid_q  <= 1'b1;
						end else begin
							st_q <= S_EDGE_RD;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (32'(clr_q) == MAX_VERTICES - 1) begin
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				S_EDGE_RD: begin
					st_q <= S_EDGE_WR;
				end
				S_EDGE_WR: begin
					out_valid_q <= 1'b1;
					st_q        <= S_IDLE;
				end
				S_P1_START: begin
					if (s_q == n_q) begin
						st_q <= S_P2_INIT;
					end else if (visited_q[s_q[IW-1:0]]) begin
						s_q <= s_q + PW'(1);
					end else begin
						cur_v_q                <= s_q[IW-1:0];
						cur_p_q                <= '0;
						sp_q                   <= '0;
						visited_q[s_q[IW-1:0]] <= 1'b1;
						st_q                   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cur_p_q == n_q) begin
						st_q <= S_FINISH;
					end else begin
						st_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (probe_hit) begin
						sp_q             <= sp_q + PW'(1);
						cur_v_q          <= p_idx;
						cur_p_q          <= '0;
						visited_q[p_idx] <= 1'b1;
						if (pass2_q) begin
							k_q      <= k_q + PW'(1);
							last_v_q <= p_idx;
						end
					end else begin
						cur_p_q <= cur_p_q + PW'(1);
					end
					st_q <= S_SCAN;
				end
				S_FINISH: begin
					if (!pass2_q) begin
						fd_q <= fd_q + PW'(1);
					end
					if (sp_q == '0) begin
						if (pass2_q) begin
							st_q <= S_P2_NEXT;
						end else begin
							s_q  <= s_q + PW'(1);
							st_q <= S_P1_START;
						end
					end else begin
						sp_q <= sp_m1;
						st_q <= S_POP;
					end
				end
				S_POP: begin
					cur_v_q <= stk_rdata[IW+PW-1:PW];
					cur_p_q <= stk_rdata[PW-1:0];
					st_q    <= S_SCAN;
				end
				S_P2_INIT: begin
					visited_q <= '0;
					pass2_q   <= 1'b1;
					comps_q   <= '0;
					k_q       <= '0;
					st_q      <= S_P2_NEXT;
				end
				S_P2_NEXT: begin
					if (fd_q == '0) begin
						e_q  <= '0;
						st_q <= S_EM_RD;
					end else begin
						fd_q <= fd_m1;
						st_q <= S_P2_GET;
					end
				end
				S_P2_GET: begin
					if (visited_q[fin_rdata]) begin
						st_q <= S_P2_NEXT;
					end else begin
						comps_q              <= comps_q + PW'(1);
						cur_v_q              <= fin_rdata;
						cur_p_q              <= '0;
						sp_q                 <= '0;
						visited_q[fin_rdata] <= 1'b1;
						k_q                  <= k_q + PW'(1);
						last_v_q             <= fin_rdata;
						st_q                 <= S_SCAN;
					end
				end
				S_EM_RD: begin
					st_q <= S_EM_LD;
				end
				S_EM_LD: begin
					out_status_q <= ST_OK;
					out_vertex_q <= 6'(7'(res_rdata[IW+PW:PW+1]) + 7'd1);
					out_comp_q   <= 6'(res_rdata[PW:1]);
					out_total_q  <= 6'(comps_q);
					out_lic_q    <= res_rdata[0];
					out_last_q   <= (e_q == k_m1);
					out_valid_q  <= 1'b1;
					e_q          <= e_q + PW'(1);
					st_q         <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (!out_valid_q) begin
						if (e_q == k_q) begin
							st_q <= S_IDLE;
						end else begin
							st_q <= S_EM_RD;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Adjacency rows: bit j of row i marks an edge from vertex i to vertex j.
	scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Walk stack of suspended vertices with their resume scan position.
	scc_ram #(.WIDTH(IW + PW), .DEPTH(MAX_VERTICES)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[IW-1:0]),
		.wdata (stk_wdata),
		.raddr (sp_m1[IW-1:0]),
		.rdata (stk_rdata)
	);

	// Finish order of the forward pass.
	scc_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_fin (
		.clk   (clk),
		.we    (fin_we),
		.waddr (fd_q[IW-1:0]),
		.wdata (cur_v_q),
		.raddr (fd_m1[IW-1:0]),
		.rdata (fin_rdata)
	);

	// Result list: vertex, component number and last-in-component flag.
	scc_ram #(.WIDTH(IW + PW + 1), .DEPTH(MAX_VERTICES)) u_res (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.raddr (e_q[IW-1:0]),
		.rdata (res_rdata)
	);

	// Output word packing.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_lic_q, out_total_q, out_comp_q, out_vertex_q};

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the strongly connected components block.
// Drives request words with random idling, predicts the component listings
// with its own Kosaraju walk, and compares every result word; needs scc_pkg.
module tb_top
	import scc_pkg::*;
();

	localparam int VMAX = 32;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] vertex;
		logic [5:0] comp;
		logic [5:0] total;
		logic       lic;
		logic       last;
	} result_t;

	typedef struct {
		logic [1:0] kind;
		logic [5:0] from_v;
		logic [5:0] to_v;
		logic [5:0] count;
		bit         typed;
		logic [1:0] status;
	} request_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	// Mirror of the graph held by the block.
	bit [VMAX-1:0] graph_rows [VMAX];
	int graph_size;
	bit graph_valid;

	result_t pending_words[$];
	int errors;
	int words_seen;
	int items_sent;
	int searches_sent;
	int cycles;
	bit hold_request;
	bit hold_done;

	strongly_connected_components dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle counter and run limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("Mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Queue the single status word of a non-listing result.
	function automatic void queue_status_word(logic [1:0] st);
		result_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		pending_words = {pending_words, r};
	endfunction

	// Kosaraju search over the mirrored graph; appends one word per vertex.
	function automatic void predict_components();
		bit [VMAX-1:0] seen;
		int order [VMAX];
		int order_depth;
		int walk [VMAX];
		int scan [VMAX];
		int depth;
		int top;
		int j;
		int comps;
		result_t listing[$];
		result_t r;
		seen = '0;
		order_depth = 0;
		for (int s = 0; s < graph_size; s++) begin
			if (seen[s])
				continue;
			walk[0] = s;
			scan[0] = 0;
			depth = 1;
			seen[s] = 1'b1;
			while (depth > 0) begin
				top = walk[depth-1];
				j = scan[depth-1];
				while (j < graph_size && !(graph_rows[top][j] && !seen[j]))
					j++;
				if (j < graph_size) begin
					scan[depth-1] = j + 1;
					walk[depth] = j;
					scan[depth] = 0;
					depth++;
					seen[j] = 1'b1;
				end else begin
					depth--;
					order[order_depth] = top;
					order_depth++;
				end
			end
		end
		// Second pass walks the transposed graph in reverse finish order.
		seen = '0;
		comps = 0;
		while (order_depth > 0) begin
			order_depth--;
			if (seen[order[order_depth]])
				continue;
			comps++;
			walk[0] = order[order_depth];
			scan[0] = 0;
			depth = 1;
			seen[walk[0]] = 1'b1;
			r = '0;
			r.vertex = walk[0] + 1;
			r.comp = comps;
			listing = {listing, r};
			while (depth > 0) begin
				top = walk[depth-1];
				j = scan[depth-1];
				while (j < graph_size && !(graph_rows[j][top] && !seen[j]))
					j++;
				if (j < graph_size) begin
					scan[depth-1] = j + 1;
					walk[depth] = j;
					scan[depth] = 0;
					depth++;
					seen[j] = 1'b1;
					r = '0;
					r.vertex = j + 1;
					r.comp = comps;
					listing = {listing, r};
				end else begin
					depth--;
				end
			end
			listing[listing.size()-1].lic = 1'b1;
		end
		listing[listing.size()-1].last = 1'b1;
		foreach (listing[i]) begin
			listing[i].total = comps;
			pending_words = {pending_words, listing[i]};
		end
	endfunction

	// Update the mirror for one accepted request; queue its words unless
	// the caller supplies them.
	function automatic void apply_request(logic [1:0] kind, logic [5:0] f,
			logic [5:0] t, logic [5:0] c, bit quiet);
		logic [1:0] st;
		st = ST_OK;
		case (kind)
			KIND_NEW: begin
				if (c < 1 || c > VMAX) begin
					st = ST_BAD_RANGE;
				end else begin
					foreach (graph_rows[i])
						graph_rows[i] = '0;
					graph_size = c;
					graph_valid = 1'b1;
				end
			end
			KIND_ADD, KIND_REMOVE: begin
				if (!graph_valid)
					st = ST_NO_GRAPH;
				else if (f == 0 || f > graph_size || t == 0 || t > graph_size)
					st = ST_BAD_RANGE;
				else
					graph_rows[f-1][t-1] = (kind == KIND_ADD);
			end
			default: begin
				if (!graph_valid) begin
					st = ST_NO_GRAPH;
				end else begin
					if (!quiet)
						predict_components();
					return;
				end
			end
		endcase
		if (!quiet)
			queue_status_word(st);
	endfunction

	// Offer one request word and wait for its acceptance.
	task automatic send_request(input request_row_t row);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.kind;
		s_tdata <= {6'd0, row.count, row.to_v, row.from_v};
		do @(posedge clk); while (!s_tready);
		apply_request(row.kind, row.from_v, row.to_v, row.count, row.typed);
		if (row.typed)
			queue_status_word(row.status);
		items_sent++;
		if (row.kind == KIND_FIND)
			searches_sent++;
	endtask

	function automatic request_row_t make_row(logic [1:0] kind, int f, int t, int c);
		request_row_t row;
		row.kind = kind;
		row.from_v = f;
		row.to_v = t;
		row.count = c;
		row.typed = 1'b0;
		row.status = ST_OK;
		return row;
	endfunction

	// Receiver: random stalls, one long hold-off on request, word checks.
	initial begin
		result_t got;
		result_t want;
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				gap = $urandom_range(0, 18);
				if ($urandom_range(0, 3) == 0)
					gap = 0;
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			words_seen++;
			got.status = m_tuser;
			got.vertex = m_tdata[5:0];
			got.comp = m_tdata[11:6];
			got.total = m_tdata[17:12];
			got.lic = m_tdata[18];
			got.last = m_tlast;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", got));
			end else begin
				want = pending_words.pop_front();
				if (got !== want || m_tdata[23:19] !== 5'd0)
					report_mismatch($sformatf(
						"st %0d/%0d v %0d/%0d c %0d/%0d tot %0d/%0d lic %b/%b last %b/%b",
						got.status, want.status, got.vertex, want.vertex, got.comp,
						want.comp, got.total, want.total, got.lic, want.lic,
						got.last, want.last));
			end
		end
	end

	// Stimulus: directed table, then random graph-building sequences.
	initial begin
		request_row_t directed[$];
		request_row_t row;
		int n;
		int edits;
		int waited;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_NEW;
		arst_n = 1'b0;
		errors = 0;
		words_seen = 0;
		items_sent = 0;
		searches_sent = 0;
		hold_request = 1'b0;
		hold_done = 1'b0;
		graph_size = 0;
		graph_valid = 1'b0;
		foreach (graph_rows[i])
			graph_rows[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			'{KIND_FIND,   0,  0,  0, 1, ST_NO_GRAPH},
			'{KIND_ADD,    1,  1,  0, 1, ST_NO_GRAPH},
			'{KIND_REMOVE, 63, 63, 63, 1, ST_NO_GRAPH},
			'{KIND_NEW,    0,  0,  0, 1, ST_BAD_RANGE},
			'{KIND_NEW,    63, 63, 63, 1, ST_BAD_RANGE},
			'{KIND_NEW,    0,  0,  33, 1, ST_BAD_RANGE},
			'{KIND_FIND,   63, 63, 63, 1, ST_NO_GRAPH},
			'{KIND_NEW,    0,  0,  32, 1, ST_OK},
			'{KIND_ADD,    32, 32, 0, 1, ST_OK},
			'{KIND_ADD,    0,  5,  0, 1, ST_BAD_RANGE},
			'{KIND_ADD,    5,  33, 0, 1, ST_BAD_RANGE},
			'{KIND_REMOVE, 63, 1,  0, 1, ST_BAD_RANGE},
			'{KIND_REMOVE, 3,  4,  0, 1, ST_OK},
			'{KIND_ADD,    1,  2,  0, 1, ST_OK},
			'{KIND_ADD,    2,  1,  0, 1, ST_OK},
			'{KIND_ADD,    1,  2,  0, 1, ST_OK},
			'{KIND_ADD,    3,  1,  0, 0, ST_OK},
			'{KIND_FIND,   0,  0,  0, 0, ST_OK},
			'{KIND_NEW,    0,  0,  1, 1, ST_OK},
			'{KIND_FIND,   0,  0,  0, 0, ST_OK},
			'{KIND_NEW,    0,  0,  4, 0, ST_OK},
			'{KIND_ADD,    5,  1,  0, 1, ST_BAD_RANGE},
			'{KIND_ADD,    4,  3,  0, 0, ST_OK},
			'{KIND_ADD,    3,  4,  0, 0, ST_OK},
			'{KIND_FIND,   0,  0,  0, 0, ST_OK}
		};
		foreach (directed[i])
			send_request(directed[i]);

		// Mostly well-formed graphs with random edges, some noise mixed in.
		while (items_sent < 200) begin
			case ($urandom_range(0, 19))
				0: n = $urandom_range(33, 63);
				1: n = 32;
				2: n = 0;
				default: n = $urandom_range(1, 8);
			endcase
			send_request(make_row(KIND_NEW, $urandom_range(0, 63),
				$urandom_range(0, 63), n));
			edits = $urandom_range(0, 2 * graph_size + 2);
			for (int e = 0; e < edits; e++) begin
				if ($urandom_range(0, 9) == 0)
					row = make_row($urandom_range(1, 2), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 63));
				else
					row = make_row(($urandom_range(0, 4) == 0) ? KIND_REMOVE : KIND_ADD,
						$urandom_range(1, graph_size), $urandom_range(1, graph_size),
						$urandom_range(0, 63));
				send_request(row);
			end
			if (items_sent > 120 && !hold_done) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			send_request(make_row(KIND_FIND, $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 63)));
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending_words.size() > 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		$display("Sent %0d requests including %0d searches; checked %0d result words.",
			items_sent, searches_sent, words_seen);
		if (errors == 0 && pending_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d words never arrived", errors,
				pending_words.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
sv/scc_pkg.sv
sv/scc_ram.sv
sv/strongly_connected_components.sv
tb/sv/tb_top.sv
